// File: hw/rtl/fenwick_tree_2d_prefix_sum_macros.svh
// Assertion macros for the 2-D Fenwick tree checker.
// Used by ft2d_chk.sv only; no other dependencies.
`ifndef FENWICK_TREE_2D_PREFIX_SUM_MACROS_SVH
`define FENWICK_TREE_2D_PREFIX_SUM_MACROS_SVH

// same-cycle implication, disabled in reset
`define FT2D_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FT2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define FT2D_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ft2d_pkg.sv
// Shared types, constants and microcode ROM for the 2-D Fenwick tree.
// No dependencies.
`timescale 1ns / 1ps

package ft2d_pkg;

    localparam int GRID_SIZE_DEF = 256;
    localparam int IDX_W         = 9;          // row/col/extent field width
    localparam int WALK_W        = IDX_W + 1;  // walk index, holds i + lowbit(i)
    localparam int DATA_W        = 32;

    localparam logic [IDX_W-1:0] EXTENT_RST = 9'd256;

    typedef enum logic [0:0] {
        FUNC_ADD   = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        STEP_CLEAR,
        STEP_IDLE,
        STEP_CHECK,
        STEP_WALK,
        STEP_DRAIN,
        STEP_EMIT
    } t_step;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IN,
        COND_CLR_DONE,
        COND_EMPTY,
        COND_WALK_DONE,
        COND_OUT_FREE
    } t_cond;

    // one control word: jump to target when cond holds, else step+1 or hold
    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  else_next;
        logic  in_rdy;
        logic  clr_wr;
        logic  load_walk;
        logic  walk_en;
        logic  emit;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic clr_done;
        logic empty;
        logic walk_done;
        logic out_free;
    } t_stat;

    function automatic t_uword ucode(t_step step);
        t_uword w;
        w = '0;
        case (step)
            STEP_CLEAR: begin
                w.cond   = COND_CLR_DONE;
                w.target = STEP_IDLE;
                w.clr_wr = 1'b1;
            end
            STEP_IDLE: begin
                w.cond   = COND_IN;
                w.target = STEP_CHECK;
                w.in_rdy = 1'b1;
            end
            STEP_CHECK: begin
                w.cond      = COND_EMPTY;
                w.target    = STEP_EMIT;
                w.else_next = 1'b1;
                w.load_walk = 1'b1;
            end
            STEP_WALK: begin
                w.cond    = COND_WALK_DONE;
                w.target  = STEP_DRAIN;
                w.walk_en = 1'b1;
            end
            STEP_DRAIN: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            STEP_EMIT: begin
                w.cond   = COND_OUT_FREE;
                w.target = STEP_IDLE;
                w.emit   = 1'b1;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/ft2d_if.sv
// Channel interfaces: item input, result output, config write.
// Depends on ft2d_pkg.
`timescale 1ns / 1ps

interface ft2d_item_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    func;
    logic        [ft2d_pkg::IDX_W-1:0]       row_index;
    logic        [ft2d_pkg::IDX_W-1:0]       col_index;
    logic signed [ft2d_pkg::DATA_W-1:0]      delta;

    modport source(output valid, func, row_index, col_index, delta, input ready);
    modport sink(input valid, func, row_index, col_index, delta, output ready);
endinterface

interface ft2d_result_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [ft2d_pkg::DATA_W-1:0]      prefix_sum;
    logic                                    bad_index;

    modport source(output valid, prefix_sum, bad_index, input ready);
    modport sink(input valid, prefix_sum, bad_index, output ready);
endinterface

interface ft2d_cfg_if;
    logic                                    valid;
    logic                                    ready;
    logic        [ft2d_pkg::IDX_W-1:0]       data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

// File: hw/rtl/fenwick_tree_2d_prefix_sum.sv
// Top level of the 2-D Fenwick tree prefix-sum block.
// Depends on ft2d_pkg, ft2d_if, ft2d_seq, ft2d_dp, ft2d_ram.
`timescale 1ns / 1ps

// Usage
//   i_item   : one transaction per item. func 0 adds delta at (row, col), func 1
//              asks for the sum over the rectangle (1,1)..(row, col).
//   o_result : exactly one transaction per item, in order. Queries return the
//              sum (wraps at 32 bits); updates return 0, with bad_index set when
//              the row or column is 0 or above the extent (update dropped).
//   i_cfg    : writes grid_extent; always ready. Write only while idle.
// Timing
//   One item at a time; each walks n tree cells: popcount(r)*popcount(c)
//   for a query (at most 64 at extent 256), up to (1 + log2 E)^2 for an update.
//   Empty queries and bad updates walk no cells. Bound by the cell RAM: one
//   read per cycle, update write-back in the cycle after the read.
// Reset
//   Synchronous, active low. The cell store is swept to zero afterwards, one
//   word per cycle: GRID_SIZE*GRID_SIZE words (65536 at default) with
//   i_item.ready low. Extent returns to 256.
// Stall
//   A held result sits in the output register; the next item is still taken
//   and worked on, and waits in its final step until the register frees up.
module fenwick_tree_2d_prefix_sum #(
    parameter int GRID_SIZE = ft2d_pkg::GRID_SIZE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ft2d_item_if.sink     i_item,
    ft2d_result_if.source o_result,
    ft2d_cfg_if.sink      i_cfg
);

    ft2d_pkg::t_uword ctl;   // current control word
    ft2d_pkg::t_stat  stat;  // jump conditions back to the sequencer

    ft2d_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (stat),
        .o_ctl  (ctl)
    );

    ft2d_dp #(
        .GRID_SIZE(GRID_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_in_valid  (i_item.valid),
        .i_func      (i_item.func),
        .i_row_index (i_item.row_index),
        .i_col_index (i_item.col_index),
        .i_delta     (i_item.delta),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_prefix_sum(o_result.prefix_sum),
        .o_bad_index (o_result.bad_index)
    );

    // only the idle step takes items
    assign i_item.ready = ctl.in_rdy;
    // register write needs no wait
    assign i_cfg.ready  = 1'b1;

endmodule

// File: hw/rtl/ft2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ft2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/ft2d_seq.sv
// Microcode sequencer: step counter, ROM lookup and jump decision.
// Depends on ft2d_pkg.
`timescale 1ns / 1ps

module ft2d_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ft2d_pkg::t_stat  i_stat,
    output ft2d_pkg::t_uword o_ctl
);

    ft2d_pkg::t_step  r_step;
    ft2d_pkg::t_step  n_step;
    ft2d_pkg::t_uword ctl;
    logic             hit;

    assign ctl = ft2d_pkg::ucode(r_step);

    always_comb begin
        case (ctl.cond)
            ft2d_pkg::COND_NEVER:     hit = 1'b0;
            ft2d_pkg::COND_ALWAYS:    hit = 1'b1;
            ft2d_pkg::COND_IN:        hit = i_stat.in_fire;
            ft2d_pkg::COND_CLR_DONE:  hit = i_stat.clr_done;
            ft2d_pkg::COND_EMPTY:     hit = i_stat.empty;
            ft2d_pkg::COND_WALK_DONE: hit = i_stat.walk_done;
            ft2d_pkg::COND_OUT_FREE:  hit = i_stat.out_free;
            default:                  hit = 1'b0;
        endcase

        if (hit) begin
            n_step = ctl.target;
        end else if (ctl.else_next) begin
            n_step = ft2d_pkg::t_step'(r_step + 3'd1);
        end else begin
            n_step = r_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ft2d_pkg::STEP_CLEAR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = ctl;

endmodule

// File: hw/rtl/ft2d_dp.sv
// Datapath: item registers, tree walk, cell store, accumulator, result register.
// Depends on ft2d_pkg and ft2d_ram.
`timescale 1ns / 1ps

module ft2d_dp #(
    parameter int GRID_SIZE = ft2d_pkg::GRID_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ft2d_pkg::t_uword                   i_ctl,
    output ft2d_pkg::t_stat                    o_stat,
    input  logic                               i_in_valid,
    input  logic                               i_func,
    input  logic        [ft2d_pkg::IDX_W-1:0]  i_row_index,
    input  logic        [ft2d_pkg::IDX_W-1:0]  i_col_index,
    input  logic signed [ft2d_pkg::DATA_W-1:0] i_delta,
    input  logic                               i_cfg_wr,
    input  logic        [ft2d_pkg::IDX_W-1:0]  i_cfg_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [ft2d_pkg::DATA_W-1:0] o_prefix_sum,
    output logic                               o_bad_index
);

    localparam int DEPTH  = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IW     = ft2d_pkg::IDX_W;
    localparam int WW     = ft2d_pkg::WALK_W;
    localparam int DW     = ft2d_pkg::DATA_W;

    logic [IW-1:0]     r_extent;
    logic [IW-1:0]     ext;
    logic [WW-1:0]     ext_w;

    logic              in_fire;
    logic [IW-1:0]     row_q;
    logic [IW-1:0]     col_q;
    logic              bad_upd;

    logic              r_query;
    logic              r_bad;
    logic              r_empty;
    logic [WW-1:0]     r_row;
    logic [WW-1:0]     r_col;
    logic [DW-1:0]     r_delta;

    logic [WW-1:0]     r_i;
    logic [WW-1:0]     r_j;
    logic [WW-1:0]     ni;
    logic [WW-1:0]     nj;
    logic              i_end;
    logic              j_end;

    logic [ADDR_W-1:0] rd_addr;
    logic              r_p_vld;
    logic [ADDR_W-1:0] r_p_addr;
    logic [DW-1:0]     rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DW-1:0]     wr_data;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [DW-1:0]     r_acc;
    logic              out_free;
    logic              r_o_vld;
    logic [DW-1:0]     r_o_sum;
    logic              r_o_bad;

    // effective extent, clamped to 1..GRID_SIZE
    always_comb begin
        if (r_extent == '0) begin
            ext = IW'(1);
        end else if (32'(r_extent) > GRID_SIZE) begin
            ext = IW'(GRID_SIZE);
        end else begin
            ext = r_extent;
        end
    end
    assign ext_w = {1'b0, ext};

    assign in_fire = i_in_valid && i_ctl.in_rdy;
    assign row_q   = (i_row_index > ext) ? ext : i_row_index;
    assign col_q   = (i_col_index > ext) ? ext : i_col_index;
    assign bad_upd = (i_row_index == '0) || (i_col_index == '0)
                  || (i_row_index > ext) || (i_col_index > ext);

    // update walks up (add lowbit), query walks down (clear lowbit)
    always_comb begin
        if (r_query) begin
            ni    = r_i & (r_i - 1'b1);
            nj    = r_j & (r_j - 1'b1);
            i_end = (ni == '0);
            j_end = (nj == '0);
        end else begin
            ni    = r_i + (r_i & (~r_i + 1'b1));
            nj    = r_j + (r_j & (~r_j + 1'b1));
            i_end = (ni > ext_w);
            j_end = (nj > ext_w);
        end
    end

    assign rd_addr = ADDR_W'(r_i - 1'b1) * ADDR_W'(GRID_SIZE) + ADDR_W'(r_j - 1'b1);

    // write port: clearing sweep, or read-modify-write in the cycle after the read
    assign wr_en   = i_ctl.clr_wr || (r_p_vld && !r_query);
    assign wr_addr = i_ctl.clr_wr ? r_clr_addr : r_p_addr;
    assign wr_data = i_ctl.clr_wr ? '0 : (rd_data + r_delta);

    ft2d_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_cells (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (i_ctl.walk_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign out_free = !r_o_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extent   <= ft2d_pkg::EXTENT_RST;
            r_clr_addr <= '0;
            r_p_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_extent <= i_cfg_data;
            end
            if (i_ctl.clr_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_p_vld <= i_ctl.walk_en;
            if (i_ctl.emit && out_free) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_query <= (i_func == ft2d_pkg::FUNC_QUERY);
            r_delta <= i_delta;
            if (i_func == ft2d_pkg::FUNC_QUERY) begin
                r_row   <= {1'b0, row_q};
                r_col   <= {1'b0, col_q};
                r_bad   <= 1'b0;
                r_empty <= (row_q == '0) || (col_q == '0);
            end else begin
                r_row   <= {1'b0, i_row_index};
                r_col   <= {1'b0, i_col_index};
                r_bad   <= bad_upd;
                r_empty <= bad_upd;
            end
        end

        if (i_ctl.load_walk) begin
            r_i <= r_row;
            r_j <= r_col;
        end else if (i_ctl.walk_en) begin
            if (!j_end) begin
                r_j <= nj;
            end else begin
                r_j <= r_col;
                r_i <= ni;
            end
        end

        if (i_ctl.walk_en) begin
            r_p_addr <= rd_addr;
        end

        if (i_ctl.load_walk) begin
            r_acc <= '0;
        end else if (r_p_vld && r_query) begin
            r_acc <= r_acc + rd_data;
        end

        if (i_ctl.emit && out_free) begin
            r_o_sum <= r_query ? r_acc : '0;
            r_o_bad <= r_bad;
        end
    end

    assign o_stat.in_fire   = in_fire;
    assign o_stat.clr_done  = i_ctl.clr_wr && (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_stat.empty     = r_empty;
    assign o_stat.walk_done = i_end && j_end;
    assign o_stat.out_free  = out_free;

    assign o_out_valid  = r_o_vld;
    assign o_prefix_sum = r_o_sum;
    assign o_bad_index  = r_o_bad;

endmodule

// File: hw/rtl/ft2d_chk.sv
// Port-level checker for the 2-D Fenwick tree, bound to the top level.
// Depends on fenwick_tree_2d_prefix_sum_macros.svh and the top level.
`timescale 1ns / 1ps
`include "fenwick_tree_2d_prefix_sum_macros.svh"

module ft2d_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_sum,
    input logic        i_out_bad
);

    `FT2D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_sum) && $stable(i_out_bad), "stalled result changed")
    `FT2D_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_out_bad, i_out_sum == '0, "flagged update with nonzero sum")
    `FT2D_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready && !$rose(i_out_valid), "item overlap after accept")
    `FT2D_ASSERT_NEXT_ALWAYS(a_rst_busy, i_clk, !i_rst_n, !i_in_ready, "ready during store clear")

endmodule

bind fenwick_tree_2d_prefix_sum ft2d_chk u_ft2d_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_item.valid),
    .i_in_ready (i_item.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_out_sum  (o_result.prefix_sum),
    .i_out_bad  (o_result.bad_index)
);

// File: sim/fenwick_tree_2d_prefix_sum_tb.sv
// Self-checking testbench for the 2-D Fenwick tree prefix-sum block.
// Depends on ft2d_pkg, ft2d_if and the block's RTL; holds its own predictor.
`timescale 1ns / 1ps

module fenwick_tree_2d_prefix_sum_tb;

    localparam int               IDX_W       = ft2d_pkg::IDX_W;
    localparam int               DATA_W      = ft2d_pkg::DATA_W;
    localparam logic [IDX_W-1:0] EXTENT_RST  = ft2d_pkg::EXTENT_RST;

    typedef ft2d_pkg::t_func t_func;
    localparam t_func            FUNC_ADD    = ft2d_pkg::FUNC_ADD;
    localparam t_func            FUNC_QUERY  = ft2d_pkg::FUNC_QUERY;

    localparam int          GRID        = ft2d_pkg::GRID_SIZE_DEF;
    // Watchdog limit, well above the clear sweep after reset plus every item
    // with random stalls on both sides.
    localparam int          CYCLE_LIMIT = 1_500_000;
    localparam int          LONG_HOLD   = 800;    // receiver hold-off, cycles
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 200;
    localparam int          PLAN_ROWS   = 29;

    // One result as the block should return it.
    typedef struct packed {
        logic [DATA_W-1:0] psum;
        logic              flag;
    } t_outcome;

    // One row of the directed plan: either an extent write (val holds the
    // extent) or an item. Where typed is set, psum/flag are the answer that
    // is checked; otherwise the predictor supplies it.
    typedef struct packed {
        logic              is_cfg;
        t_func             func;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] val;
        logic              typed;
        logic [DATA_W-1:0] psum;
        logic              flag;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ft2d_item_if   item_ch ();
    ft2d_result_if res_ch ();
    ft2d_cfg_if    cfg_ch ();

    fenwick_tree_2d_prefix_sum dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the tree store and of the extent
    // register, both at their reset values. Reset is applied once only.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] shadow_cells [GRID*GRID];
    logic [IDX_W-1:0]  model_extent = EXTENT_RST;
    t_outcome          expected_sums [$];

    initial begin
        foreach (shadow_cells[k]) begin
            shadow_cells[k] = '0;
        end
    end

    // Directed rows ride alongside the item payload so that the checker
    // samples them at the same edge as the transaction itself.
    logic              dir_typed = 1'b0;
    logic [DATA_W-1:0] dir_psum  = '0;
    logic              dir_flag  = 1'b0;

    // Shared knobs between the stimulus and the receiver process.
    bit idle_en  = 1'b1;   // random bursts of idling on both sides
    bit hold_req = 1'b0;   // ask the receiver for one long hold-off

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned queries_seen   = 0;
    int unsigned updates_seen   = 0;
    int unsigned flagged_seen   = 0;
    int unsigned extent_writes  = 0;
    int unsigned holds_done     = 0;

    // Extent register as the tree walk sees it: 0 acts as 1, above the
    // grid acts as the grid size.
    function automatic int clamp_extent(logic [IDX_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID) return GRID;
        return int'(v);
    endfunction

    function automatic int lowbit(int v);
        return v & (-v);
    endfunction

    // Applies one item to the shadow store and returns the result it
    // should produce. Query indices are clamped to the extent, a zero index
    // gives an empty walk. Updates outside 1..E are dropped and flagged.
    function automatic t_outcome fenwick_apply(t_func f, int r, int c,
                                               logic [DATA_W-1:0] d);
        int       e;
        t_outcome o;
        e = clamp_extent(model_extent);
        o = '0;
        if (f == FUNC_QUERY) begin
            if (r > e) r = e;
            if (c > e) c = e;
            for (int i = r; i >= 1; i -= lowbit(i)) begin
                for (int j = c; j >= 1; j -= lowbit(j)) begin
                    o.psum += shadow_cells[(i - 1) * GRID + (j - 1)];
                end
            end
        end else if (r == 0 || c == 0 || r > e || c > e) begin
            o.flag = 1'b1;
        end else begin
            // covering cells stop at the current extent, not at the grid
            for (int i = r; i <= e; i += lowbit(i)) begin
                for (int j = c; j <= e; j += lowbit(j)) begin
                    shadow_cells[(i - 1) * GRID + (j - 1)] += d;
                end
            end
        end
        return o;
    endfunction

    function automatic void report_miss(string field, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checker: every edge, take in extent writes and accepted items
    // (predict and queue), then compare any accepted result with the
    // oldest expectation. One block keeps the push/pop order fixed.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                model_extent = cfg_ch.data;
                extent_writes++;
            end
            if (item_ch.valid && item_ch.ready) begin
                want = fenwick_apply(t_func'(item_ch.func), int'(item_ch.row_index),
                                     int'(item_ch.col_index), item_ch.delta);
                if (item_ch.func == FUNC_QUERY) queries_seen++;
                else updates_seen++;
                if (want.flag) flagged_seen++;
                if (dir_typed) begin
                    want.psum = dir_psum;
                    want.flag = dir_flag;
                end
                expected_sums.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_sums.size() == 0) begin
                    report_miss("unexpected result, prefix_sum", '0, res_ch.prefix_sum);
                end else begin
                    want = expected_sums.pop_front();
                    if (res_ch.prefix_sum !== want.psum) begin
                        report_miss("prefix_sum", want.psum, res_ch.prefix_sum);
                    end
                    if (res_ch.bad_index !== want.flag) begin
                        report_miss("bad_index", DATA_W'(want.flag), DATA_W'(res_ch.bad_index));
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_sums.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: short random stalls while idling is on, and one long
    // hold-off on request so the output register fills, the block holds
    // a second finished item and then drops its input ready.
    // ------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                res_ch.ready <= 1'b1;
                hold_req = 1'b0;
                holds_done++;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge it is accepted. Valid stays
    // high into the next item unless a random gap is taken here.
    task automatic offer_item(t_func f, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                              logic [DATA_W-1:0] d, logic typed,
                              logic [DATA_W-1:0] want_psum, logic want_flag);
        item_ch.valid     <= 1'b1;
        item_ch.func      <= f;
        item_ch.row_index <= r;
        item_ch.col_index <= c;
        item_ch.delta     <= d;
        dir_typed         <= typed;
        dir_psum          <= want_psum;
        dir_flag          <= want_flag;
        do @(posedge i_clk); while (!item_ch.ready);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    // Every item yields a result, so an empty queue means the block is idle.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_sums.size() != 0);
    endtask

    // Extent writes only happen with the block idle.
    task automatic write_extent(logic [IDX_W-1:0] v);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Index picker: mostly inside 1..E, with zero, the extent itself and
    // values above it (up to the full 9-bit range) mixed in.
    function automatic logic [IDX_W-1:0] pick_index(int e);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4) return '0;
        if (roll < 10) return IDX_W'($urandom_range(e + 1, (1 << IDX_W) - 1));
        if (roll < 16) return IDX_W'(e);
        return IDX_W'($urandom_range(1, e));
    endfunction

    function automatic logic [DATA_W-1:0] pick_delta();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Directed plan. Typed answers only where they are obvious: empty
    // store after reset, zero-index queries, flagged and accepted updates,
    // and the max+min sum. Everything else goes through the predictor.
    t_plan_row directed_plan [PLAN_ROWS] = '{
        // empty store right after the clear sweep
        '{1'b0, FUNC_QUERY, 9'd256, 9'd256, 32'h0000_1234, 1'b1, 32'd0, 1'b0},
        // zero row / zero column query: empty walk
        '{1'b0, FUNC_QUERY, 9'd0,   9'd5,   32'd0,         1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd7,   9'd0,   32'd0,         1'b1, 32'd0, 1'b0},
        // bad updates: zero index, above extent, far above extent
        '{1'b0, FUNC_ADD,   9'd0,   9'd3,   32'd5,         1'b1, 32'd0, 1'b1},
        '{1'b0, FUNC_ADD,   9'd3,   9'd0,   32'd5,         1'b1, 32'd0, 1'b1},
        '{1'b0, FUNC_ADD,   9'd257, 9'd1,   32'd9,         1'b1, 32'd0, 1'b1},
        '{1'b0, FUNC_ADD,   9'd1,   9'd511, 32'd9,         1'b1, 32'd0, 1'b1},
        // corner updates with extreme deltas
        '{1'b0, FUNC_ADD,   9'd1,   9'd1,   32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd256, 9'd256, 32'h8000_0000, 1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd256, 9'd256, 32'd0,         1'b1, 32'hFFFF_FFFF, 1'b0},
        // indices above extent clamp; delta on a query is ignored
        '{1'b0, FUNC_QUERY, 9'd511, 9'd511, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd1,   9'd1,   32'hDEAD_BEEF, 1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd5,   9'd9,   32'hFFFF_FFF9, 1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd5,   9'd9,   32'd0,         1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd4,   9'd9,   32'd0,         1'b0, 32'd0, 1'b0},
        // extent 0 behaves as 1
        '{1'b1, FUNC_ADD,   9'd0,   9'd0,   32'd0,         1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd1,   9'd1,   32'd3,         1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd2,   9'd1,   32'd3,         1'b1, 32'd0, 1'b1},
        '{1'b0, FUNC_QUERY, 9'd300, 9'd300, 32'd0,         1'b0, 32'd0, 1'b0},
        // extent beyond the grid behaves as the grid size
        '{1'b1, FUNC_ADD,   9'd0,   9'd0,   32'd511,       1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd256, 9'd1,   32'd1,         1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd256, 9'd1,   32'd0,         1'b0, 32'd0, 1'b0},
        // shrink the extent over a populated store: no rebuild
        '{1'b1, FUNC_ADD,   9'd0,   9'd0,   32'd5,         1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd8,   9'd8,   32'd0,         1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_ADD,   9'd6,   9'd2,   32'd1,         1'b1, 32'd0, 1'b1},
        '{1'b0, FUNC_ADD,   9'd5,   9'd5,   32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd5,   9'd5,   32'd0,         1'b0, 32'd0, 1'b0},
        // grow it back: queries walk cells left over from the small extent
        '{1'b1, FUNC_ADD,   9'd0,   9'd0,   32'd256,       1'b0, 32'd0, 1'b0},
        '{1'b0, FUNC_QUERY, 9'd256, 9'd256, 32'd0,         1'b0, 32'd0, 1'b0}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed plan, then random phases each under
    // its own extent. Phase 3 carries the long receiver hold-off, phase 5
    // a full pause of the sender, the last phase runs with no idling.
    // ------------------------------------------------------------------
    initial begin
        logic [IDX_W-1:0] phase_ext;
        int               eff;
        t_func            f;

        item_ch.valid     = 1'b0;
        item_ch.func      = FUNC_ADD;
        item_ch.row_index = '0;
        item_ch.col_index = '0;
        item_ch.delta     = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = EXTENT_RST;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first item waits out the clear sweep on the input handshake
        foreach (directed_plan[k]) begin
            if (directed_plan[k].is_cfg) begin
                write_extent(directed_plan[k].val[IDX_W-1:0]);
            end else begin
                offer_item(directed_plan[k].func, directed_plan[k].row,
                           directed_plan[k].col, directed_plan[k].val,
                           directed_plan[k].typed, directed_plan[k].psum,
                           directed_plan[k].flag);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       phase_ext = 9'd256;
                1:       phase_ext = 9'd1;
                2:       phase_ext = 9'd2;
                3:       phase_ext = 9'd511;
                4:       phase_ext = IDX_W'($urandom_range(3, 40));
                5:       phase_ext = 9'd16;
                6:       phase_ext = IDX_W'($urandom_range(41, 511));
                default: phase_ext = 9'd256;
            endcase
            write_extent(phase_ext);
            eff     = clamp_extent(phase_ext);
            idle_en = (ph != PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == 40) hold_req = 1'b1;
                if (ph == 5 && n == PHASE_ITEMS / 2) wait_idle();
                f = ($urandom_range(0, 99) < 55) ? FUNC_ADD : FUNC_QUERY;
                offer_item(f, pick_index(eff), pick_index(eff), pick_delta(),
                           1'b0, '0, 1'b0);
            end
        end

        wait_idle();
        // wait on for any stray result to show up
        repeat (200) @(posedge i_clk);

        if (expected_sums.size() != 0) begin
            $display("%0d expected results never arrived", expected_sums.size());
            mismatch_count += expected_sums.size();
        end
        $display("Covered %0d queries and %0d updates (%0d flagged) over %0d extent writes,",
                 queries_seen, updates_seen, flagged_seen, extent_writes);
        $display("%0d results checked, %0d long output hold-off(s), %0d mismatches.",
                 results_seen, holds_done, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
